>>> hdl/ars_pkg.sv
// types, register offsets and helpers shared by the audio register shadow
package ars_pkg;

    // request kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // global register offsets
    localparam logic [11:0] REG_DMA_CONTROL = 12'h096;
    localparam logic [11:0] REG_IRQ_ENABLE  = 12'h09A;
    localparam logic [11:0] REG_IRQ_REQUEST = 12'h09C;
    localparam logic [11:0] REG_MOD_CONTROL = 12'h09E;

    // channel window, 16 bytes per channel
    localparam logic [11:0] CH_BASE = 12'h0A0;
    localparam logic [11:0] CH_LAST = 12'h0DA;

    // channel sub-offsets
    localparam logic [3:0] SUB_LOC_HI = 4'd0;
    localparam logic [3:0] SUB_LOC_LO = 4'd2;
    localparam logic [3:0] SUB_LENGTH = 4'd4;
    localparam logic [3:0] SUB_PERIOD = 4'd6;
    localparam logic [3:0] SUB_VOLUME = 4'd8;
    localparam logic [3:0] SUB_SAMPLE = 4'd10;

    // set/clear control bit and master dma enable bit
    localparam int SET_BIT        = 15;
    localparam int DMA_MASTER_BIT = 9;

    typedef struct packed {
        logic        mode;
        logic [11:0] address;
        logic [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        recognized;
        logic [3:0]  dma_channel_flags;
        logic [31:0] applied_total;
        logic [31:0] ignored_total;
        logic [31:0] sample_write_total;
        logic [31:0] channel_write_total;
    } out_item_t;

    // decoded offset
    typedef struct packed {
        logic       glb_dma;
        logic       glb_ien;
        logic       glb_irq;
        logic       glb_mod;
        logic       ch_hit;
        logic [1:0] ch_idx;
        logic [3:0] sub;
    } decode_t;

    // set bits when bit 15 is high, otherwise clear them
    function automatic logic [14:0] set_clear(input logic [14:0] cur, input logic [15:0] v);
        logic [14:0] res;
        if (v[SET_BIT])
            res = cur | v[14:0];
        else
            res = cur & ~v[14:0];
        return res;
    endfunction

endpackage

>>> hdl/ars_decode.sv
// register offset decoder for the audio register shadow
module ars_decode #(
    parameter int CHANNELS = 4
) (
    input  logic [11:0]     address,
    output ars_pkg::decode_t dec
);
    import ars_pkg::*;

    logic [11:0] ch_off;
    logic        in_window;

    // global registers and channel window
    always_comb
    begin
        ch_off      = address - CH_BASE;
        in_window   = (address >= CH_BASE) && (address <= CH_LAST);
        dec.glb_dma = (address == REG_DMA_CONTROL);
        dec.glb_ien = (address == REG_IRQ_ENABLE);
        dec.glb_irq = (address == REG_IRQ_REQUEST);
        dec.glb_mod = (address == REG_MOD_CONTROL);
        dec.ch_idx  = ch_off[5:4];
        dec.sub     = ch_off[3:0];
        // absent channels fall back to unmapped
        dec.ch_hit  = in_window && ({1'b0, ch_off[5:4]} < 3'(CHANNELS));
    end

endmodule

>>> hdl/audio_register_shadow.sv
// top level of the audio dma register shadow with counters
// Usage:
//   Requests arrive on in_valid/in_ready with in_item (mode, address, value).
//   Mode write updates the shadow at the 12-bit offset; mode read only
//   reports. Global registers use set/clear writes selected by value bit 15.
//   Every request yields exactly one result on out_valid/out_ready carrying
//   the shadow of the addressed register after the request, a recognized
//   flag, per-channel dma enable flags and the write counters.
//   Result: registered as the request is taken, offered in the next cycle.
//   Throughput: one request per cycle; decode, read-modify-write of the flop
//   file and readback all fit between the input port and the result register.
//   Stall: while a result waits and out_ready is low, in_ready drops; a new
//   request is taken in the same cycle the waiting result leaves.
//   Reset: rst_n clears the shadow registers and counters (periods reset
//   to 1) and no result is pending; the result payload is not reset.
module audio_register_shadow #(
    parameter int CHANNELS    = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ars_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ars_pkg::out_item_t out_item
);
    import ars_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    decode_t dec;
    logic    accept;
    logic    wr;
    logic [IDX_W-1:0] ch_sel;

    // global registers
    logic [14:0] dma_reg, dma_next;
    logic [14:0] ien_reg, ien_next;
    logic [14:0] irq_reg, irq_next;
    logic [14:0] mod_reg, mod_next;

    // per-channel registers
    logic [31:0] loc_reg [CHANNELS];
    logic [31:0] loc_next [CHANNELS];
    logic [15:0] len_reg [CHANNELS];
    logic [15:0] len_next [CHANNELS];
    logic [15:0] per_reg [CHANNELS];
    logic [15:0] per_next [CHANNELS];
    logic [6:0]  vol_reg [CHANNELS];
    logic [6:0]  vol_next [CHANNELS];
    logic [15:0] smp_reg [CHANNELS];
    logic [15:0] smp_next [CHANNELS];
    logic [COUNT_WIDTH-1:0] chw_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0] chw_next [CHANNELS];
    logic [CHANNELS-1:0]    en_reg, en_next;

    // counters
    logic [COUNT_WIDTH-1:0] applied_reg, applied_next;
    logic [COUNT_WIDTH-1:0] ignored_reg, ignored_next;
    logic [COUNT_WIDTH-1:0] swr_reg, swr_next;

    // result register
    out_item_t result;
    out_item_t out_item_reg;
    logic      out_valid_reg, out_valid_next;

    ars_decode #(
        .CHANNELS(CHANNELS)
    ) u_decode (
        .address(in_item.address),
        .dec    (dec)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign wr       = accept && (in_item.mode == MODE_WRITE);
    assign ch_sel   = dec.ch_idx[IDX_W-1:0];

    // write decode and state update
    always_comb
    begin
        dma_next     = dma_reg;
        ien_next     = ien_reg;
        irq_next     = irq_reg;
        mod_next     = mod_reg;
        loc_next     = loc_reg;
        len_next     = len_reg;
        per_next     = per_reg;
        vol_next     = vol_reg;
        smp_next     = smp_reg;
        chw_next     = chw_reg;
        en_next      = en_reg;
        applied_next = applied_reg;
        ignored_next = ignored_reg;
        swr_next     = swr_reg;
        if (wr)
        begin
            applied_next = applied_reg + 1'b1;
            priority if (dec.glb_dma)
            begin
                dma_next = set_clear(dma_reg, in_item.value);
                for (int c = 0; c < CHANNELS; c++)
                begin
                    en_next[c] = dma_next[DMA_MASTER_BIT] & dma_next[c];
                end
            end
            else if (dec.glb_ien)
            begin
                ien_next = set_clear(ien_reg, in_item.value);
            end
            else if (dec.glb_irq)
            begin
                irq_next = set_clear(irq_reg, in_item.value);
            end
            else if (dec.glb_mod)
            begin
                mod_next = set_clear(mod_reg, in_item.value);
            end
            else if (dec.ch_hit)
            begin
                chw_next[ch_sel] = chw_reg[ch_sel] + 1'b1;
                unique case (dec.sub)
                    SUB_LOC_HI: loc_next[ch_sel][31:16] = in_item.value;
                    SUB_LOC_LO: loc_next[ch_sel][15:0]  = in_item.value;
                    SUB_LENGTH: len_next[ch_sel] = in_item.value;
                    SUB_PERIOD: per_next[ch_sel] = in_item.value;
                    SUB_VOLUME: vol_next[ch_sel] = in_item.value[6:0];
                    SUB_SAMPLE:
                    begin
                        smp_next[ch_sel] = in_item.value;
                        swr_next         = swr_reg + 1'b1;
                    end
                    default:    ignored_next = ignored_reg + 1'b1;
                endcase
            end
            else
            begin
                ignored_next = ignored_reg + 1'b1;
            end
        end
    end

    // readback from the updated shadow
    always_comb
    begin
        result                     = '0;
        result.recognized          = 1'b1;
        result.applied_total       = 32'(applied_next);
        result.ignored_total       = 32'(ignored_next);
        result.sample_write_total  = 32'(swr_next);
        for (int c = 0; c < CHANNELS; c++)
        begin
            result.dma_channel_flags[c] = en_next[c];
        end
        if (dec.ch_hit)
        begin
            result.channel_write_total = 32'(chw_next[ch_sel]);
        end
        priority if (dec.glb_dma)
            result.read_data = {1'b0, dma_next};
        else if (dec.glb_ien)
            result.read_data = {1'b0, ien_next};
        else if (dec.glb_irq)
            result.read_data = {1'b0, irq_next};
        else if (dec.glb_mod)
            result.read_data = {1'b0, mod_next};
        else if (dec.ch_hit && dec.sub == SUB_LOC_HI)
            result.read_data = loc_next[ch_sel][31:16];
        else if (dec.ch_hit && dec.sub == SUB_LOC_LO)
            result.read_data = loc_next[ch_sel][15:0];
        else if (dec.ch_hit && dec.sub == SUB_LENGTH)
            result.read_data = len_next[ch_sel];
        else if (dec.ch_hit && dec.sub == SUB_PERIOD)
            result.read_data = per_next[ch_sel];
        else if (dec.ch_hit && dec.sub == SUB_VOLUME)
            result.read_data = {9'd0, vol_next[ch_sel]};
        else if (dec.ch_hit && dec.sub == SUB_SAMPLE)
            result.read_data = smp_next[ch_sel];
        else
            result.recognized = 1'b0;
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // shadow state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dma_reg       <= '0;
            ien_reg       <= '0;
            irq_reg       <= '0;
            mod_reg       <= '0;
            en_reg        <= '0;
            applied_reg   <= '0;
            ignored_reg   <= '0;
            swr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                loc_reg[c] <= '0;
                len_reg[c] <= '0;
                per_reg[c] <= 16'd1;
                vol_reg[c] <= '0;
                smp_reg[c] <= '0;
                chw_reg[c] <= '0;
            end
        end
        else
        begin
            dma_reg       <= dma_next;
            ien_reg       <= ien_next;
            irq_reg       <= irq_next;
            mod_reg       <= mod_next;
            en_reg        <= en_next;
            applied_reg   <= applied_next;
            ignored_reg   <= ignored_next;
            swr_reg       <= swr_next;
            out_valid_reg <= out_valid_next;
            loc_reg       <= loc_next;
            len_reg       <= len_next;
            per_reg       <= per_next;
            vol_reg       <= vol_next;
            smp_reg       <= smp_next;
            chw_reg       <= chw_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> tb/sv/tb_audio_register_shadow.sv
// self-checking testbench for the audio register shadow with its own register predictor
`timescale 1ns / 1ps

module tb_audio_register_shadow;

    import ars_pkg::*;

    localparam int NUM_CH       = 4;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_EVERY  = 350;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 4;

    // receiver stall styles
    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE, RX_HOLD} rx_style_t;

    // register shadow predictor and queue of expected readbacks
    class shadow_scoreboard;
        logic [14:0] dma_ctl, irq_en, irq_req, mod_ctl;
        logic [31:0] loc[NUM_CH];
        logic [15:0] len[NUM_CH];
        logic [15:0] per[NUM_CH];
        logic [6:0]  vol[NUM_CH];
        logic [15:0] word[NUM_CH];
        logic [31:0] ch_writes[NUM_CH];
        logic [3:0]  enabled;
        logic [31:0] applied, ignored, samples;
        out_item_t   expected_readback[$];
        int          mismatch_count;

        function new();
            dma_ctl = '0;
            irq_en = '0;
            irq_req = '0;
            mod_ctl = '0;
            enabled = '0;
            applied = '0;
            ignored = '0;
            samples = '0;
            mismatch_count = 0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                loc[c] = '0;
                len[c] = '0;
                per[c] = 16'd1;
                vol[c] = '0;
                word[c] = '0;
                ch_writes[c] = '0;
            end
        endfunction

        // bit 15 picks or-in versus and-not of the low bits
        function logic [14:0] apply_set_clear(logic [14:0] cur, logic [15:0] v);
            return v[15] ? (cur | v[14:0]) : (cur & ~v[14:0]);
        endfunction

        function int pending();
            return expected_readback.size();
        endfunction

        // update the shadow for an accepted request and queue its readback
        function void note_request(in_item_t req);
            out_item_t   res;
            logic [11:0] off;
            int unsigned ch;
            logic [3:0]  sub;
            logic        hit;
            off = req.address - CH_BASE;
            ch  = off >> 4;
            sub = off[3:0];
            hit = (req.address >= CH_BASE) && (req.address <= CH_LAST) && (ch < NUM_CH);

            // write side
            if (req.mode == MODE_WRITE)
            begin
                applied = applied + 1;
                case (req.address)
                    REG_DMA_CONTROL:
                    begin
                        dma_ctl = apply_set_clear(dma_ctl, req.value);
                        for (int c = 0; c < NUM_CH; c++)
                            enabled[c] = dma_ctl[DMA_MASTER_BIT] & dma_ctl[c];
                    end
                    REG_IRQ_ENABLE:  irq_en  = apply_set_clear(irq_en, req.value);
                    REG_IRQ_REQUEST: irq_req = apply_set_clear(irq_req, req.value);
                    REG_MOD_CONTROL: mod_ctl = apply_set_clear(mod_ctl, req.value);
                    default:
                    begin
                        if (hit)
                        begin
                            case (sub)
                                SUB_LOC_HI: loc[ch][31:16] = req.value;
                                SUB_LOC_LO: loc[ch][15:0]  = req.value;
                                SUB_LENGTH: len[ch] = req.value;
                                SUB_PERIOD: per[ch] = req.value;
                                SUB_VOLUME: vol[ch] = req.value[6:0];
                                SUB_SAMPLE:
                                begin
                                    word[ch] = req.value;
                                    samples = samples + 1;
                                end
                                default: ignored = ignored + 1;
                            endcase
                            ch_writes[ch] = ch_writes[ch] + 1;
                        end
                        else
                            ignored = ignored + 1;
                    end
                endcase
            end

            // readback after the request
            res = '0;
            res.recognized = 1'b1;
            case (req.address)
                REG_DMA_CONTROL: res.read_data = {1'b0, dma_ctl};
                REG_IRQ_ENABLE:  res.read_data = {1'b0, irq_en};
                REG_IRQ_REQUEST: res.read_data = {1'b0, irq_req};
                REG_MOD_CONTROL: res.read_data = {1'b0, mod_ctl};
                default:
                begin
                    if (hit)
                    begin
                        case (sub)
                            SUB_LOC_HI: res.read_data = loc[ch][31:16];
                            SUB_LOC_LO: res.read_data = loc[ch][15:0];
                            SUB_LENGTH: res.read_data = len[ch];
                            SUB_PERIOD: res.read_data = per[ch];
                            SUB_VOLUME: res.read_data = {9'b0, vol[ch]};
                            SUB_SAMPLE: res.read_data = word[ch];
                            default:    res.recognized = 1'b0;
                        endcase
                    end
                    else
                        res.recognized = 1'b0;
                end
            endcase
            res.dma_channel_flags   = enabled;
            res.applied_total       = applied;
            res.ignored_total       = ignored;
            res.sample_write_total  = samples;
            res.channel_write_total = hit ? ch_writes[ch] : 32'd0;
            expected_readback.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        // compare an accepted result with the oldest expected readback
        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_readback.size() == 0)
            begin
                $error("result with no request outstanding: read_data %0h", got.read_data);
                mismatch_count++;
                return;
            end
            want = expected_readback.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("recognized", want.recognized, got.recognized);
            compare_field("dma_channel_flags", want.dma_channel_flags, got.dma_channel_flags);
            compare_field("applied_total", want.applied_total, got.applied_total);
            compare_field("ignored_total", want.ignored_total, got.ignored_total);
            compare_field("sample_write_total", want.sample_write_total,
                          got.sample_write_total);
            compare_field("channel_write_total", want.channel_write_total,
                          got.channel_write_total);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    shadow_scoreboard board = new();

    audio_register_shadow dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // request builders
    function automatic in_item_t make_req(logic mode, logic [11:0] addr, logic [15:0] value);
        in_item_t req;
        req.mode    = mode;
        req.address = addr;
        req.value   = value;
        return req;
    endfunction

    function automatic logic [11:0] chan_addr(int unsigned ch, logic [3:0] sub);
        return CH_BASE + 12'(ch * 16) + {8'h00, sub};
    endfunction

    // mostly mapped registers, some dead channel slots and random offsets
    function automatic in_item_t random_request();
        logic        mode;
        logic [11:0] addr;
        logic [3:0]  sub;
        int          pick;
        mode = ($urandom_range(0, 99) < 30) ? MODE_READ : MODE_WRITE;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            case ($urandom_range(0, 3))
                0:       addr = REG_DMA_CONTROL;
                1:       addr = REG_IRQ_ENABLE;
                2:       addr = REG_IRQ_REQUEST;
                default: addr = REG_MOD_CONTROL;
            endcase
        end
        else if (pick < 76)
        begin
            sub  = 4'(2 * $urandom_range(0, 5));
            addr = chan_addr($urandom_range(0, NUM_CH - 1), sub);
        end
        else if (pick < 86)
        begin
            if ($urandom_range(0, 1) != 0)
                sub = 4'(2 * $urandom_range(0, 7) + 1);
            else
                sub = 4'(12 + 2 * $urandom_range(0, 1));
            addr = chan_addr($urandom_range(0, NUM_CH - 1), sub);
        end
        else
            addr = 12'($urandom_range(0, 4095));
        return make_req(mode, addr, 16'($urandom_range(0, 65535)));
    endfunction

    // offer one request and hold it until taken
    task automatic send_request(in_item_t req);
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(req);
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop offering until every expected result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_item);
    end

    // receiver stall pattern, with a long hold-off every few stretches
    initial
    begin : receiver
        rx_style_t style;
        int        span;
        int        stretch_no;
        out_ready = 1'b0;
        stretch_no = 0;
        forever
        begin
            style = rx_style_t'($urandom_range(0, 3));
            span  = $urandom_range(16, 96);
            if (stretch_no % 6 == 2)
            begin
                style = RX_HOLD;
                span  = HOLD_CYCLES;
            end
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (style)
                    RX_STEADY:   out_ready <= 1'b1;
                    RX_RANDOM:   out_ready <= ($urandom_range(0, 1) != 0);
                    RX_PERIODIC: out_ready <= (k % 3 != 0);
                    RX_SPARSE:   out_ready <= ($urandom_range(0, 4) == 0);
                    default:     out_ready <= 1'b0;
                endcase
            end
            stretch_no++;
        end
    end

    // cycle limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // reset, directed requests, random requests, then drain and report
    initial
    begin : stimulus
        int sent;
        int burst;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset values, set/clear edges, every channel register, dead offsets
        send_request(make_req(MODE_READ,  REG_DMA_CONTROL, 16'h0000));
        send_request(make_req(MODE_READ,  chan_addr(0, SUB_PERIOD), 16'hFFFF));
        send_request(make_req(MODE_READ,  chan_addr(3, SUB_PERIOD), 16'h0000));
        send_request(make_req(MODE_WRITE, REG_DMA_CONTROL, 16'hFFFF));
        send_request(make_req(MODE_WRITE, REG_DMA_CONTROL, 16'h0200));
        send_request(make_req(MODE_WRITE, REG_DMA_CONTROL, 16'h8205));
        send_request(make_req(MODE_WRITE, REG_IRQ_ENABLE,  16'hFFFF));
        send_request(make_req(MODE_WRITE, REG_IRQ_ENABLE,  16'h7FFF));
        send_request(make_req(MODE_WRITE, REG_IRQ_REQUEST, 16'h8000));
        send_request(make_req(MODE_WRITE, REG_MOD_CONTROL, 16'hAAAA));
        send_request(make_req(MODE_WRITE, chan_addr(0, SUB_LOC_HI), 16'hFFFF));
        send_request(make_req(MODE_WRITE, chan_addr(0, SUB_LOC_LO), 16'h0000));
        send_request(make_req(MODE_WRITE, chan_addr(1, SUB_LENGTH), 16'hFFFF));
        send_request(make_req(MODE_WRITE, chan_addr(2, SUB_PERIOD), 16'h0000));
        send_request(make_req(MODE_WRITE, chan_addr(3, SUB_VOLUME), 16'hFFFF));
        send_request(make_req(MODE_WRITE, CH_LAST, 16'h1234));
        send_request(make_req(MODE_WRITE, chan_addr(1, 4'd1), 16'h5555));
        send_request(make_req(MODE_WRITE, chan_addr(2, 4'd12), 16'h0F0F));
        send_request(make_req(MODE_WRITE, chan_addr(2, 4'd14), 16'hF0F0));
        send_request(make_req(MODE_WRITE, CH_LAST + 12'd1, 16'hBEEF));
        send_request(make_req(MODE_WRITE, 12'h000, 16'h0000));
        send_request(make_req(MODE_WRITE, 12'hFFF, 16'hFFFF));
        send_request(make_req(MODE_READ,  12'hFFF, 16'hFFFF));
        send_request(make_req(MODE_READ,  chan_addr(3, SUB_VOLUME), 16'h0000));
        send_request(make_req(MODE_READ,  chan_addr(0, SUB_LOC_HI), 16'h0000));
        wait_drained();

        // random bursts with random gaps
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_request(random_request());
                sent++;
                if (sent % DRAIN_EVERY == 0)
                    wait_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end

        // drain and let stray results show up
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
